// ===== design/mclp_pkg.sv =====
// Package for the multi-channel LED PWM block.
// Holds sizes, command codes and the word types of both channels; no dependencies.
package mclp_pkg;

    localparam int CHANNELS    = 30;
    localparam int FRAME_TICKS = 128;

    localparam int PATTERN_W = 30;
    localparam int ADDR_W    = 5;
    localparam int DUTY_W    = 8;
    localparam int TICK_W    = (FRAME_TICKS > 1) ? $clog2(FRAME_TICKS) : 1;
    // Internal pattern vector wide enough for every channel and every output bit.
    localparam int WIDE_W    = (CHANNELS > PATTERN_W) ? CHANNELS : PATTERN_W;

    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    typedef struct packed {
        logic              command;
        logic [ADDR_W-1:0] led_address;
        logic [DUTY_W-1:0] duty;
        logic              is_led_module;
    } t_in_word;

    typedef struct packed {
        logic [PATTERN_W-1:0] led_pattern;
        logic                 write_accepted;
    } t_out_word;

endpackage

// ===== design/mclp_core.sv =====
// PWM state and per-word computation: duty store, on-counters, frame position.
// Uses mclp_pkg for sizes, command codes and word types.
module mclp_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  mclp_pkg::t_in_word  i_word,
    output mclp_pkg::t_out_word o_word
);

    logic [mclp_pkg::DUTY_W-1:0]    r_duty [mclp_pkg::CHANNELS];
    logic [mclp_pkg::DUTY_W-1:0]    n_duty [mclp_pkg::CHANNELS];
    logic [mclp_pkg::DUTY_W-1:0]    r_rem  [mclp_pkg::CHANNELS];
    logic [mclp_pkg::DUTY_W-1:0]    n_rem  [mclp_pkg::CHANNELS];
    logic [mclp_pkg::TICK_W-1:0]    r_tick;
    logic [mclp_pkg::TICK_W-1:0]    n_tick;
    logic [mclp_pkg::PATTERN_W-1:0] r_last;
    logic [mclp_pkg::PATTERN_W-1:0] n_last;

    logic                          is_write;
    logic                          addr_ok;
    logic                          wr_en;
    logic [mclp_pkg::WIDE_W-1:0]   wide_pattern;
    logic [mclp_pkg::DUTY_W-1:0]   cur;

    assign is_write = (i_word.command == mclp_pkg::CMD_WRITE);
    assign addr_ok  = (i_word.led_address != '0) &&
                      (32'(i_word.led_address) <= mclp_pkg::CHANNELS);
    assign wr_en    = is_write && i_word.is_led_module && addr_ok;

    always_comb begin
        wide_pattern = '0;
        n_tick       = r_tick;
        n_last       = r_last;
        cur          = '0;
        for (int ch = 0; ch < mclp_pkg::CHANNELS; ch++) begin
            n_duty[ch] = r_duty[ch];
            n_rem[ch]  = r_rem[ch];
        end
        if (i_push && is_write) begin
            for (int ch = 0; ch < mclp_pkg::CHANNELS; ch++) begin
                if (wr_en && (32'(i_word.led_address) == ch + 1)) begin
                    n_duty[ch] = i_word.duty;
                end
            end
        end else if (i_push) begin
            // The first tick of a frame reloads every counter from its duty.
            for (int ch = 0; ch < mclp_pkg::CHANNELS; ch++) begin
                cur = (r_tick == '0) ? r_duty[ch] : r_rem[ch];
                if (cur != '0) begin
                    wide_pattern[ch] = 1'b1;
                    n_rem[ch]        = cur - 1'b1;
                end else begin
                    n_rem[ch] = cur;
                end
            end
            n_last = wide_pattern[mclp_pkg::PATTERN_W-1:0];
            if (r_tick == mclp_pkg::TICK_W'(mclp_pkg::FRAME_TICKS - 1)) begin
                n_tick = '0;
            end else begin
                n_tick = r_tick + 1'b1;
            end
        end
    end

    always_comb begin
        o_word.write_accepted = wr_en;
        o_word.led_pattern    = is_write ? r_last : n_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick <= '0;
            r_last <= '0;
            for (int ch = 0; ch < mclp_pkg::CHANNELS; ch++) begin
                r_duty[ch] <= '0;
                r_rem[ch]  <= '0;
            end
        end else begin
            r_tick <= n_tick;
            r_last <= n_last;
            for (int ch = 0; ch < mclp_pkg::CHANNELS; ch++) begin
                r_duty[ch] <= n_duty[ch];
                r_rem[ch]  <= n_rem[ch];
            end
        end
    end

endmodule

// ===== design/mclp_skid.sv =====
// Two-entry output buffer for result words, so one more word is taken while
// the consumer stalls. Uses mclp_pkg for the result word type.
module mclp_skid (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  mclp_pkg::t_out_word i_word,
    output logic                o_space,
    output logic                o_valid,
    input  logic                i_ready,
    output mclp_pkg::t_out_word o_word
);

    logic                r_v0;
    logic                r_v1;
    logic                n_v0;
    logic                n_v1;
    mclp_pkg::t_out_word r_q0;
    mclp_pkg::t_out_word r_q1;
    mclp_pkg::t_out_word n_q0;
    mclp_pkg::t_out_word n_q1;
    logic                pop;

    assign pop     = r_v0 && i_ready;
    assign o_space = !r_v1;
    assign o_valid = r_v0;
    assign o_word  = r_q0;

    always_comb begin
        n_v0 = r_v0;
        n_v1 = r_v1;
        n_q0 = r_q0;
        n_q1 = r_q1;
        if (pop) begin
            if (r_v1) begin
                n_q0 = r_q1;
                if (i_push) begin
                    n_q1 = i_word;
                end else begin
                    n_v1 = 1'b0;
                end
            end else if (i_push) begin
                n_q0 = i_word;
            end else begin
                n_v0 = 1'b0;
            end
        end else if (i_push) begin
            if (!r_v0) begin
                n_q0 = i_word;
                n_v0 = 1'b1;
            end else begin
                n_q1 = i_word;
                n_v1 = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else begin
            r_v0 <= n_v0;
            r_v1 <= n_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q0 <= n_q0;
        r_q1 <= n_q1;
    end

endmodule

// ===== design/multi_channel_led_pwm.sv =====
// Multi-channel LED PWM: one word in, one result word out. A result is computed
// combinationally in mclp_core and registered in mclp_skid. Throughput is one word
// per cycle while the buffer has space, set by the parallel update of all channel
// counters in mclp_core; the two-entry buffer takes one more word on a stall.
// Synchronous active-low reset clears duties, counters, frame position, pattern.
// Depends on mclp_pkg, mclp_core and mclp_skid.
module multi_channel_led_pwm (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  mclp_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output mclp_pkg::t_out_word o_out_word
);

    logic                push;
    logic                space;
    mclp_pkg::t_out_word core_word;

    assign o_in_ready = space;
    assign push       = i_in_valid && space;

    mclp_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_word  (i_in_word),
        .o_word  (core_word)
    );

    mclp_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_word  (core_word),
        .o_space (space),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_word  (o_out_word)
    );

endmodule
